@@ rtl/gps_pkg.sv @@
package gps_pkg;

  // Frame codes; codes six and seven are never reached and act as an analog poll.
  localparam logic [2:0] FR_DIGITAL = 3'd0;
  localparam logic [2:0] FR_ENTER   = 3'd1;
  localparam logic [2:0] FR_LOCK    = 3'd2;
  localparam logic [2:0] FR_MAP     = 3'd3;
  localparam logic [2:0] FR_EXIT    = 3'd4;
  localparam logic [2:0] FR_ANALOG  = 3'd5;

  // Item operations.
  localparam logic OP_START = 1'b0;
  localparam logic OP_BYTE  = 1'b1;

  // Register byte addresses.
  localparam logic [2:0] ADDR_ANALOG_ENABLE = 3'd0;

  // Frame lengths in byte slots.
  localparam logic [3:0] SHORT_FRAME_LEN = 4'd5;
  localparam logic [3:0] LONG_FRAME_LEN  = 4'd9;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic        attention_low;
    logic        frame_done;
    logic [15:0] buttons;
    logic [7:0]  right_x;
    logic [7:0]  right_y;
    logic [7:0]  left_x;
    logic [7:0]  left_y;
  } result_t;

  // Command byte sent in a given slot of a given frame.
  function automatic logic [7:0] cmd_for(input logic [2:0] frame, input logic [3:0] slot,
                                         input logic [7:0] motor);
    logic [7:0] cmd;
    cmd = 8'h00;
    case (frame)
      FR_DIGITAL: begin
        case (slot)
          4'd0:    cmd = 8'h01;
          4'd1:    cmd = 8'h42;
          default: cmd = 8'h00;
        endcase
      end
      FR_ENTER: begin
        case (slot)
          4'd0:    cmd = 8'h01;
          4'd1:    cmd = 8'h43;
          4'd3:    cmd = 8'h01;
          default: cmd = 8'h00;
        endcase
      end
      FR_LOCK: begin
        case (slot)
          4'd0:    cmd = 8'h01;
          4'd1:    cmd = 8'h44;
          4'd3:    cmd = 8'h01;
          4'd4:    cmd = 8'h03;
          default: cmd = 8'h00;
        endcase
      end
      FR_MAP: begin
        case (slot)
          4'd0:                         cmd = 8'h01;
          4'd1:                         cmd = 8'h4D;
          4'd4:                         cmd = 8'h01;
          4'd5, 4'd6, 4'd7, 4'd8:       cmd = 8'hFF;
          default:                      cmd = 8'h00;
        endcase
      end
      FR_EXIT: begin
        case (slot)
          4'd0:                         cmd = 8'h01;
          4'd1:                         cmd = 8'h43;
          4'd4, 4'd5, 4'd6, 4'd7, 4'd8: cmd = 8'h5A;
          default:                      cmd = 8'h00;
        endcase
      end
      default: begin
        case (slot)
          4'd0:       cmd = 8'h01;
          4'd1:       cmd = 8'h42;
          4'd3, 4'd4: cmd = motor;
          default:    cmd = 8'h00;
        endcase
      end
    endcase
    return cmd;
  endfunction

endpackage

@@ rtl/gamepad_poll_sequencer.sv @@
// Channel    | Signals                                   | Payload
// item       | item_valid, item_stall, item              | gps_pkg::item_t
// result     | result_valid, result_stall, result        | gps_pkg::result_t
// config     | psel, penable, pwrite, paddr, pwdata, ... | analog_enable at 0x0
//
// One item is taken per cycle while item_stall is low; each item gives one result
// through the input register, then the sequencer step into the result register.
// The sequencer step is a table lookup and a few compares between the two registers.
// Reset (rst, synchronous) empties both registers and returns to the first digital poll.
// A stalled result holds; item_stall rises once the input register is full and cannot drain.
module gamepad_poll_sequencer #(
  parameter int INIT_POLLS = 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  gps_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output gps_pkg::result_t  result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import gps_pkg::*;

  localparam logic [1:0] InitPolls = 2'(INIT_POLLS);

  logic        analog_enable;
  logic        in_valid;
  item_t       in_item;
  logic        advance;

  logic [2:0]  frame_index, frame_index_next;
  logic [3:0]  slot_index, slot_index_next;
  logic [1:0]  init_poll_count, init_poll_count_next;
  logic [7:0]  motor_level, motor_level_next;
  logic [15:0] button_latch, button_latch_next;
  logic [7:0]  axis_latch [4];
  logic [7:0]  axis_latch_next [4];
  logic        frame_active, frame_active_next;
  logic [7:0]  capture [6];
  logic [7:0]  capture_next [6];
  result_t     result_next;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ANALOG_ENABLE) ? {31'd0, analog_enable} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      analog_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_ANALOG_ENABLE) begin
      analog_enable <= pwdata[0];
    end
  end

  // Handshake: the input register drains whenever the result register is free.
  assign advance    = in_valid && (!result_valid || !result_stall);
  assign item_stall = in_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      in_item <= item;
    end
  end

  // Sequencer step for the transaction in the input register.
  always_comb begin
    logic [3:0] slot_inc;
    logic [3:0] frame_len;
    frame_index_next     = frame_index;
    slot_index_next      = slot_index;
    init_poll_count_next = init_poll_count;
    motor_level_next     = motor_level;
    button_latch_next    = button_latch;
    axis_latch_next      = axis_latch;
    frame_active_next    = frame_active;
    capture_next         = capture;
    result_next          = '0;
    slot_inc             = slot_index + 4'd1;
    frame_len            = (frame_index == FR_DIGITAL || frame_index == FR_ENTER)
                           ? SHORT_FRAME_LEN : LONG_FRAME_LEN;

    if (in_item.operation == OP_START) begin
      // Start a frame; digital if analog is off, setup once initial polls are done.
      if (!analog_enable) begin
        frame_index_next     = FR_DIGITAL;
        init_poll_count_next = 2'd0;
      end else if (frame_index == FR_DIGITAL && init_poll_count >= InitPolls) begin
        frame_index_next = FR_ENTER;
      end
      frame_active_next         = 1'b1;
      slot_index_next           = 4'd0;
      result_next.cmd_byte      = cmd_for(frame_index_next, 4'd0, motor_level);
      result_next.attention_low = 1'b1;
    end else if (frame_active) begin
      // Slots three to eight are captured.
      for (int i = 0; i < 6; i++) begin
        if (slot_index == 4'(i + 3)) begin
          capture_next[i] = in_item.rx_byte;
        end
      end
      if (slot_inc >= frame_len) begin
        frame_active_next      = 1'b0;
        slot_index_next        = 4'd0;
        result_next.frame_done = 1'b1;
        if (frame_index == FR_DIGITAL) begin
          button_latch_next = {capture_next[1], capture_next[0]};
          if (analog_enable && init_poll_count < InitPolls) begin
            init_poll_count_next = init_poll_count + 2'd1;
          end
        end else if (frame_index >= FR_ANALOG) begin
          button_latch_next  = {capture_next[1], capture_next[0]};
          axis_latch_next[0] = capture_next[2];
          axis_latch_next[1] = capture_next[3];
          axis_latch_next[2] = capture_next[4];
          axis_latch_next[3] = capture_next[5];
          motor_level_next   = capture_next[1][0] ? 8'h00 : 8'hFF;
        end else begin
          frame_index_next = frame_index + 3'd1;
        end
      end else begin
        slot_index_next           = slot_inc;
        result_next.cmd_byte      = cmd_for(frame_index, slot_inc, motor_level);
        result_next.attention_low = 1'b1;
      end
    end

    result_next.buttons = button_latch_next;
    result_next.right_x = axis_latch_next[0];
    result_next.right_y = axis_latch_next[1];
    result_next.left_x  = axis_latch_next[2];
    result_next.left_y  = axis_latch_next[3];
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_index     <= FR_DIGITAL;
      slot_index      <= 4'd0;
      init_poll_count <= 2'd0;
      motor_level     <= 8'h00;
      button_latch    <= 16'hFFFF;
      axis_latch      <= '{default: 8'h00};
      frame_active    <= 1'b0;
      capture         <= '{default: 8'h00};
    end else if (advance) begin
      frame_index     <= frame_index_next;
      slot_index      <= slot_index_next;
      init_poll_count <= init_poll_count_next;
      motor_level     <= motor_level_next;
      button_latch    <= button_latch_next;
      axis_latch      <= axis_latch_next;
      frame_active    <= frame_active_next;
      capture         <= capture_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  // A transaction that ends a frame releases attention.
  a_done_releases: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.frame_done) |-> !result.attention_low)
    else $error("frame_done with attention still low");

  // The frame is no longer active after its last byte.
  a_done_clears_active: assert property (@(posedge clk) disable iff (rst)
    (advance && result_next.frame_done) |=> !frame_active)
    else $error("frame still active after its last byte");

  // The initial poll count never runs past its limit.
  a_init_count_bound: assert property (@(posedge clk) disable iff (rst)
    init_poll_count <= InitPolls || INIT_POLLS == 0 && init_poll_count == 2'd0)
    else $error("initial poll count past its limit");

  // The motor level is either fully off or fully on.
  a_motor_level: assert property (@(posedge clk) disable iff (rst)
    motor_level == 8'h00 || motor_level == 8'hFF)
    else $error("motor level not off or full");
`endif

endmodule
